>>> hdl/mesh_area_signed_volume_assert.svh
// assertion macros for the mesh area and volume block
`ifndef MESH_AREA_SIGNED_VOLUME_ASSERT_SVH
`define MESH_AREA_SIGNED_VOLUME_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MAS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mas_pkg.sv
// shared widths, constants and state type for the mesh area and volume block
`default_nettype none
package mas_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned EdgeW  = CoordW + 1;
  localparam int unsigned OpW    = 2 * EdgeW + 1;
  localparam int unsigned ProdW  = 2 * OpW;
  localparam int unsigned AccW   = ProdW + 2;
  localparam int unsigned CrsW   = OpW;
  localparam int unsigned TcrW   = 2 * CoordW + 1;
  localparam int unsigned TriW   = TcrW + CoordW + 2;
  localparam int unsigned RootW  = AccW / 2;
  localparam int unsigned AreaW  = 63;
  localparam int unsigned VolW   = 64;
  localparam int unsigned StepW  = 5;
  localparam int unsigned NumSteps = 18;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SQRT,
    S_ACC,
    S_FIN
  } state_e;
endpackage
`default_nettype wire

>>> hdl/mas_isqrt.sv
// bit-serial integer square root, two radicand bits per cycle
`default_nettype none
module mas_isqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mas_pkg::AccW-1:0]      rad_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [mas_pkg::RootW-1:0]          root_o
);
  localparam int unsigned RemW = mas_pkg::RootW + 3;
  localparam int unsigned CntW = $clog2(mas_pkg::RootW + 1);

  logic [mas_pkg::AccW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]           rem_q, rem_d, rem_sh, trial;
  logic [mas_pkg::RootW-1:0] root_q, root_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      done_q, done_d;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_sh = {rem_q[RemW-3:0], rad_q[mas_pkg::AccW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(mas_pkg::RootW);
    end else if (cnt_q != '0) begin
      rad_d = {rad_q[mas_pkg::AccW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[mas_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[mas_pkg::RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

>>> hdl/mesh_area_signed_volume.sv
// top level: mesh surface area and signed volume accumulator
//
//  channel | dir | handshake               | payload
//  vertex  | in  | in_valid_i / in_ready_o | vertex_x/y/z, face_end, mesh_end, body_closed
//  result  | out | out_valid_o/out_ready_i | twice_area, six_volume, normals_outward,
//          |     |                         | sum_overflow
//
//  first two vertices of a face: each accept is followed by the finish state, then idle
//  later vertices: 18 products on the one shared multiplier, then a wait on the
//  bit-serial square root (36 steps and its done flag), one accumulate, finish and idle
//  reset clears the sums, face position and handshake flags at once
//  a mesh-end item waits in its finish state while the previous result is not taken
`default_nettype none
`include "mesh_area_signed_volume_assert.svh"
module mesh_area_signed_volume (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [15:0]         vertex_x_i,
  input  wire logic signed [15:0]         vertex_y_i,
  input  wire logic signed [15:0]         vertex_z_i,
  input  wire logic                       face_end_i,
  input  wire logic                       mesh_end_i,
  input  wire logic                       body_closed_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [62:0]                     twice_area_o,
  output logic signed [63:0]              six_volume_o,
  output logic                            normals_outward_o,
  output logic                            sum_overflow_o
);
  localparam int unsigned CW = mas_pkg::CoordW;
  localparam int unsigned EW = mas_pkg::EdgeW;
  localparam int unsigned OW = mas_pkg::OpW;

  mas_pkg::state_e state_q, state_d;

  logic signed [CW-1:0] org_q [3], org_d [3];
  logic signed [CW-1:0] prv_q [3], prv_d [3];
  logic signed [CW-1:0] cur_q [3], cur_d [3];
  logic signed [EW-1:0] e1_q [3], e1_d [3];
  logic signed [EW-1:0] e2_q [3], e2_d [3];
  logic signed [mas_pkg::CrsW-1:0] crs_q [3], crs_d [3];
  logic signed [mas_pkg::TcrW-1:0] tcr_q [3], tcr_d [3];
  logic signed [CW-1:0] vin [3];

  logic [1:0] pos_q, pos_d;
  logic       mesh_q, mesh_d, closed_q, closed_d;
  logic [mas_pkg::StepW-1:0] step_q, step_d, acc_idx;
  logic signed [OW-1:0] op_a, op_b;
  logic signed [mas_pkg::ProdW-1:0] prod_q, prod_d;
  logic signed [mas_pkg::AccW-1:0] acc_q, acc_d, prod_ext;
  logic signed [mas_pkg::TriW-1:0] tri_q, tri_d;

  logic [mas_pkg::AreaW-1:0] area_q, area_d;
  logic signed [mas_pkg::VolW-1:0] vol_q, vol_d;
  logic ovf_q, ovf_d;
  logic [mas_pkg::AreaW:0] area_sum;
  logic signed [mas_pkg::VolW:0] vol_sum;

  logic out_valid_q, out_valid_d;
  logic [mas_pkg::AreaW-1:0] oarea_q, oarea_d;
  logic signed [mas_pkg::VolW-1:0] ovol_q, ovol_d;
  logic onorm_q, onorm_d, oovf_q, oovf_d;

  logic sq_start, sq_busy, sq_done;
  logic [mas_pkg::RootW-1:0] sq_root;
  logic in_acc, out_free;

  assign vin[0]   = vertex_x_i;
  assign vin[1]   = vertex_y_i;
  assign vin[2]   = vertex_z_i;
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign acc_idx  = step_q - 1'b1;

  mas_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (acc_d),
    .busy_o  (sq_busy),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mas_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (pos_q == 2'd2) ? mas_pkg::S_MUL : mas_pkg::S_FIN;
        end
      end
      mas_pkg::S_MUL: begin
        if (step_q == mas_pkg::StepW'(mas_pkg::NumSteps)) begin
          state_d = mas_pkg::S_SQRT;
        end
      end
      mas_pkg::S_SQRT: begin
        if (sq_done) begin
          state_d = mas_pkg::S_ACC;
        end
      end
      mas_pkg::S_ACC: state_d = mas_pkg::S_FIN;
      mas_pkg::S_FIN: begin
        if (!mesh_q || out_free) begin
          state_d = mas_pkg::S_IDLE;
        end
      end
      default: state_d = mas_pkg::S_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      5'd0:  begin op_a = OW'(e1_q[1]);  op_b = OW'(e2_q[2]);  end
      5'd1:  begin op_a = OW'(e1_q[2]);  op_b = OW'(e2_q[1]);  end
      5'd2:  begin op_a = OW'(e1_q[2]);  op_b = OW'(e2_q[0]);  end
      5'd3:  begin op_a = OW'(e1_q[0]);  op_b = OW'(e2_q[2]);  end
      5'd4:  begin op_a = OW'(e1_q[0]);  op_b = OW'(e2_q[1]);  end
      5'd5:  begin op_a = OW'(e1_q[1]);  op_b = OW'(e2_q[0]);  end
      5'd6:  begin op_a = OW'(prv_q[1]); op_b = OW'(cur_q[2]); end
      5'd7:  begin op_a = OW'(prv_q[2]); op_b = OW'(cur_q[1]); end
      5'd8:  begin op_a = OW'(prv_q[2]); op_b = OW'(cur_q[0]); end
      5'd9:  begin op_a = OW'(prv_q[0]); op_b = OW'(cur_q[2]); end
      5'd10: begin op_a = OW'(prv_q[0]); op_b = OW'(cur_q[1]); end
      5'd11: begin op_a = OW'(prv_q[1]); op_b = OW'(cur_q[0]); end
      5'd12: begin op_a = OW'(org_q[0]); op_b = OW'(tcr_q[0]); end
      5'd13: begin op_a = OW'(org_q[1]); op_b = OW'(tcr_q[1]); end
      5'd14: begin op_a = OW'(org_q[2]); op_b = OW'(tcr_q[2]); end
      5'd15: begin op_a = crs_q[0];      op_b = crs_q[0];      end
      5'd16: begin op_a = crs_q[1];      op_b = crs_q[1];      end
      5'd17: begin op_a = crs_q[2];      op_b = crs_q[2];      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // datapath
  always_comb begin
    org_d = org_q; prv_d = prv_q; cur_d = cur_q;
    e1_d = e1_q; e2_d = e2_q; crs_d = crs_q; tcr_d = tcr_q;
    pos_d = pos_q; mesh_d = mesh_q; closed_d = closed_q;
    step_d = step_q; prod_d = prod_q; acc_d = acc_q; tri_d = tri_q;
    area_d = area_q; vol_d = vol_q; ovf_d = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    oarea_d = oarea_q; ovol_d = ovol_q; onorm_d = onorm_q; oovf_d = oovf_q;
    sq_start = 1'b0;
    prod_ext = mas_pkg::AccW'(prod_q);
    area_sum = {1'b0, area_q} + (mas_pkg::AreaW+1)'(sq_root);
    vol_sum  = {vol_q[mas_pkg::VolW-1], vol_q} + (mas_pkg::VolW+1)'(tri_q);

    case (state_q)
      mas_pkg::S_IDLE: begin
        if (in_acc) begin
          mesh_d   = mesh_end_i;
          closed_d = body_closed_i;
          step_d   = '0;
          for (int i = 0; i < 3; i++) begin
            if (pos_q == 2'd0) begin
              org_d[i] = vin[i];
            end else if (pos_q == 2'd1) begin
              prv_d[i] = vin[i];
            end else begin
              cur_d[i] = vin[i];
              e1_d[i]  = EW'(prv_q[i]) - EW'(org_q[i]);
              e2_d[i]  = EW'(vin[i]) - EW'(org_q[i]);
            end
          end
          if (face_end_i || mesh_end_i) begin
            pos_d = 2'd0;
          end else if (pos_q != 2'd2) begin
            pos_d = pos_q + 2'd1;
          end
        end
      end
      mas_pkg::S_MUL: begin
        prod_d = op_a * op_b;
        step_d = step_q + 1'b1;
        if (step_q != '0) begin
          case (acc_idx) inside
            5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd15: acc_d = prod_ext;
            5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11: acc_d = acc_q - prod_ext;
            default: acc_d = acc_q + prod_ext;
          endcase
          case (acc_idx)
            5'd1:  crs_d[0] = acc_d[mas_pkg::CrsW-1:0];
            5'd3:  crs_d[1] = acc_d[mas_pkg::CrsW-1:0];
            5'd5:  crs_d[2] = acc_d[mas_pkg::CrsW-1:0];
            5'd7:  tcr_d[0] = acc_d[mas_pkg::TcrW-1:0];
            5'd9:  tcr_d[1] = acc_d[mas_pkg::TcrW-1:0];
            5'd11: tcr_d[2] = acc_d[mas_pkg::TcrW-1:0];
            5'd14: tri_d    = acc_d[mas_pkg::TriW-1:0];
            default: ;
          endcase
        end
        if (step_q == mas_pkg::StepW'(mas_pkg::NumSteps)) begin
          sq_start = 1'b1;
        end
      end
      mas_pkg::S_SQRT: ;
      mas_pkg::S_ACC: begin
        prv_d = cur_q;
        if (area_sum[mas_pkg::AreaW]) begin
          area_d = '1;
          ovf_d  = 1'b1;
        end else begin
          area_d = area_sum[mas_pkg::AreaW-1:0];
        end
        if (vol_sum[mas_pkg::VolW] != vol_sum[mas_pkg::VolW-1]) begin
          vol_d = vol_sum[mas_pkg::VolW] ? {1'b1, {(mas_pkg::VolW-1){1'b0}}}
                                         : {1'b0, {(mas_pkg::VolW-1){1'b1}}};
          ovf_d = 1'b1;
        end else begin
          vol_d = vol_sum[mas_pkg::VolW-1:0];
        end
      end
      mas_pkg::S_FIN: begin
        if (mesh_q && out_free) begin
          out_valid_d = 1'b1;
          oarea_d = area_q;
          ovol_d  = vol_q;
          onorm_d = closed_q && (vol_q > 0);
          oovf_d  = ovf_q;
          area_d  = '0;
          vol_d   = '0;
          ovf_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mas_pkg::S_IDLE;
      pos_q       <= 2'd0;
      area_q      <= '0;
      vol_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      org_q       <= '{default: '0};
      prv_q       <= '{default: '0};
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      area_q      <= area_d;
      vol_q       <= vol_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      org_q       <= org_d;
      prv_q       <= prv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    e1_q     <= e1_d;
    e2_q     <= e2_d;
    crs_q    <= crs_d;
    tcr_q    <= tcr_d;
    mesh_q   <= mesh_d;
    closed_q <= closed_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    tri_q    <= tri_d;
    oarea_q  <= oarea_d;
    ovol_q   <= ovol_d;
    onorm_q  <= onorm_d;
    oovf_q   <= oovf_d;
  end

  assign in_ready_o        = (state_q == mas_pkg::S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign twice_area_o      = oarea_q;
  assign six_volume_o      = ovol_q;
  assign normals_outward_o = onorm_q;
  assign sum_overflow_o    = oovf_q;

  `MAS_ASSERT(a_idle_sqrt, state_q == mas_pkg::S_IDLE, !sq_busy, "sqrt busy while idle")
  `MAS_ASSERT(a_done_state, sq_done, state_q == mas_pkg::S_SQRT, "sqrt done outside sqrt")
  `MAS_ASSERT(a_norm_pos, out_valid_o && normals_outward_o, six_volume_o > 0, "outward flag with nonpositive volume")
  `MAS_ASSERT_NXT(a_start_busy, sq_start, sq_busy, "sqrt did not start")
endmodule
`default_nettype wire
